@@ sv/u8u16_pkg.sv @@
package u8u16_pkg;

  // Width of one input byte and of one UTF-16 code unit.
  localparam int unsigned ByteW = 8;
  localparam int unsigned UnitW = 16;

  // Result buffer: room for two surrogate pairs.
  localparam int unsigned RbufDepth = 4;
  localparam int unsigned RbufPtrW  = $clog2(RbufDepth);
  localparam int unsigned RbufCntW  = $clog2(RbufDepth + 1);

  // Surrogate construction. The high unit is (cp >> 10) + 0xD800 - 0x40,
  // taken modulo 2^16, so the two constants are folded into one.
  localparam logic [UnitW-1:0] HiSurrBias  = 16'hD7C0;
  localparam logic [UnitW-1:0] LoSurrBase  = 16'hDC00;

  // One result as it leaves the block.
  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             last;
    logic             bad;
  } result_t;

  // Results pushed by one input transaction: none, one or two.
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

@@ sv/utf8_to_utf16_transcoder_core.sv @@
// Channel   Direction  tdata             tlast     tuser
// s_axis    in         in_byte [7:0]     -         -
// m_axis    out        out_unit [15:0]   run_last  bad_lead
//
// One byte is taken per cycle; the shift-add into the accumulator and the
// surrogate split sit between the state registers and a four-entry result
// buffer. A surrogate pair leaves the output as two results, high unit first.
// Input stalls only when fewer than two buffer entries are free, so the input
// ready does not depend on the output ready in the same cycle.
// Asynchronous active-low reset clears the open sequence and empties the buffer.
module utf8_to_utf16_transcoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] out_unit
  output logic        m_axis_tlast_o,   // run_last
  output logic        m_axis_tuser_o    // [0] bad_lead
);

  // The accumulator holds the running value with the lead and continuation
  // marker bits already removed, so a finished sequence is the code point.
  logic [31:0] acc_q, acc_d;
  logic [1:0]  left_q, left_d;

  logic                    accept;
  logic                    done;
  logic                    bad;
  logic [31:0]             cp;
  logic [u8u16_pkg::ByteW-1:0] byte_in;
  u8u16_pkg::push_t        push;
  u8u16_pkg::result_t      head;

  assign byte_in = s_axis_tdata_i;
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;

  // Byte decode and accumulation.
  always_comb begin
    acc_d  = acc_q;
    left_d = left_q;
    done   = 1'b0;
    bad    = 1'b0;
    if (left_q != 2'd0) begin
      // Continuation byte: add (byte - 0x80), sign-extended.
      acc_d  = {acc_q[25:0], 6'b0}
             + {{24{~byte_in[7]}}, ~byte_in[7], byte_in[6:0]};
      left_d = left_q - 2'd1;
      done   = left_q == 2'd1;
    end else if (byte_in[7:6] != 2'b11) begin
      acc_d = {24'b0, byte_in};
      done  = 1'b1;
    end else if (!byte_in[5]) begin
      acc_d  = {27'b0, byte_in[4:0]};
      left_d = 2'd1;
    end else if (!byte_in[4]) begin
      acc_d  = {28'b0, byte_in[3:0]};
      left_d = 2'd2;
    end else if (!byte_in[3]) begin
      acc_d  = {29'b0, byte_in[2:0]};
      left_d = 2'd3;
    end else begin
      bad = 1'b1;
    end
    cp = acc_d;
  end

  // Build the results of this transaction.
  always_comb begin
    push = '0;
    if (accept) begin
      if (bad) begin
        push.num         = 2'd1;
        push.first.unit  = '0;
        push.first.last  = 1'b1;
        push.first.bad   = 1'b1;
      end else if (done) begin
        if (cp[31:16] != 16'h0000) begin
          push.num         = 2'd2;
          push.first.unit  = cp[25:10] + u8u16_pkg::HiSurrBias;
          push.first.last  = 1'b0;
          push.second.unit = u8u16_pkg::LoSurrBase | {6'b0, cp[9:0]};
          push.second.last = 1'b1;
        end else begin
          push.num        = 2'd1;
          push.first.unit = cp[15:0];
          push.first.last = 1'b1;
        end
      end
    end
  end

  // Sequence state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      left_q <= '0;
    end else if (accept) begin
      acc_q  <= acc_d;
      left_q <= left_d;
    end
  end

  u8u16_rbuf u_rbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (s_axis_tready_o),
    .pop_valid_o (m_axis_tvalid_o),
    .pop_ready_i (m_axis_tready_i),
    .pop_data_o  (head)
  );

  assign m_axis_tdata_o = head.unit;
  assign m_axis_tlast_o = head.last;
  assign m_axis_tuser_o = head.bad;

endmodule

@@ sv/u8u16_rbuf.sv @@
module u8u16_rbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  u8u16_pkg::push_t     push_i,
  output logic                 room_o,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output u8u16_pkg::result_t   pop_data_o
);

  u8u16_pkg::result_t mem [u8u16_pkg::RbufDepth];

  logic [u8u16_pkg::RbufPtrW-1:0] wr_q, wr_d;
  logic [u8u16_pkg::RbufPtrW-1:0] rd_q, rd_d;
  logic [u8u16_pkg::RbufCntW-1:0] cnt_q, cnt_d;
  logic [u8u16_pkg::RbufPtrW-1:0] wr_next;
  logic                           pop;

  // Room for a full pair is kept free, so the input side never waits on
  // the output handshake within the same cycle.
  assign room_o      = cnt_q <= u8u16_pkg::RbufCntW'(u8u16_pkg::RbufDepth - 2);
  assign pop_valid_o = cnt_q != '0;
  assign pop_data_o  = mem[rd_q];
  assign pop         = pop_valid_o && pop_ready_i;
  assign wr_next     = wr_q + u8u16_pkg::RbufPtrW'(1);

  // Pointer and fill count arithmetic.
  always_comb begin
    wr_d  = wr_q + u8u16_pkg::RbufPtrW'(push_i.num);
    rd_d  = rd_q + u8u16_pkg::RbufPtrW'(pop);
    cnt_d = cnt_q + u8u16_pkg::RbufCntW'(push_i.num) - u8u16_pkg::RbufCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage; the second result of a pair goes to the following slot.
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem[wr_next] <= push_i.second;
    end
  end

endmodule

@@ sv/u8u16_checker.sv @@
module u8u16_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        m_axis_tuser_o
);

  // Nothing is offered on the output in the cycle after reset is seen.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid after reset");

  // An error result is a single zero unit that closes its run.
  a_bad_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tlast_o && m_axis_tdata_o == 16'h0000))
    else $error("malformed error result");

  // The low surrogate is buffered together with the high one.
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=>
      (m_axis_tvalid_o && m_axis_tlast_o && !m_axis_tuser_o))
    else $error("high surrogate not followed by low surrogate");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

endmodule

bind utf8_to_utf16_transcoder_core u8u16_checker u_checker (.*);
